// File: src/brce_pkg.sv
// ----------------------------------------------------------------------------
// brce_pkg
// Shared types and constants of the BER REAL content encoder.
// ----------------------------------------------------------------------------
package brce_pkg;

    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        KIND_FINITE,
        KIND_INF,
        KIND_ZERO,
        KIND_NAN
    } kind_t;

    localparam logic [7:0]  OCT_POS_INF = 8'h40;
    localparam logic [7:0]  OCT_NEG_INF = 8'h41;
    localparam logic [7:0]  FMT_BINARY  = 8'h80;
    localparam logic [7:0]  FMT_NEG     = 8'h40;
    localparam logic [10:0] EXP_SPECIAL = 11'h7ff;
    localparam logic [11:0] EXP_BIAS    = 12'd1022;
    localparam logic [11:0] EXP_DENORM  = 12'hc03;  // -1021

    // One classified value, ready for octet emission
    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic        xlen2;     // exponent takes two octets
        logic [11:0] xexp;      // two's complement exponent X
        logic [2:0]  mlen;      // significand octets, 1..7
        logic [55:0] sig;       // left-aligned significand
        logic [3:0]  total;     // content octet count
    } desc_t;

endpackage

// File: src/brce_ifs.sv
// ----------------------------------------------------------------------------
// brce_ifs
// Valid/ready channels of the encoder: value input and octet output.
// ----------------------------------------------------------------------------
interface brce_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink (input valid, input value_bits, output ready);
endinterface

interface brce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet;
    logic       last;
    logic       empty_res;
    logic       invalid;
    logic [3:0] content_length;

    modport source (
        output valid, output octet, output last, output empty_res,
        output invalid, output content_length, input ready
    );
    modport sink (
        input valid, input octet, input last, input empty_res,
        input invalid, input content_length, output ready
    );
endinterface

// File: src/brce_front.sv
// ----------------------------------------------------------------------------
// brce_front
// Accepts a binary64 pattern, classifies it, normalizes denormals one byte
// per cycle, then sizes exponent and significand and hands a descriptor on.
// ----------------------------------------------------------------------------
module brce_front (
    input  logic            clk,
    input  logic            rst_n,
    brce_in_if.sink         req,
    output logic            desc_valid,
    input  logic            desc_ready,
    output brce_pkg::desc_t desc
);
    import brce_pkg::*;

    logic        busy_reg;
    kind_t       kind_reg;
    logic        neg_reg;
    logic [52:0] sig_reg;
    logic [11:0] e_reg;

    logic        accept;
    logic        done;
    logic        norm_step;
    logic [10:0] bexp;
    logic [51:0] frac;
    kind_t       kind_in;
    logic [2:0]  lz;
    logic [55:0] sig56;
    logic [2:0]  mlen;
    logic [11:0] xexp;
    logic        xlen2;

    function automatic logic [2:0] lead_zeros(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!found)
            begin
                if (b[i])
                    found = 1'b1;
                else
                    n = n + 3'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] sig_len(input logic [55:0] s);
        logic [2:0] n;
        n = 3'd1;
        for (int i = 0; i < 7; i++)
        begin
            if (s[55 - 8 * i -: 8] != 8'h00)
                n = 3'(i + 1);
        end
        return n;
    endfunction

    assign bexp = req.value_bits[62:52];
    assign frac = req.value_bits[51:0];

    always_comb
    begin
        if (bexp == EXP_SPECIAL)
            kind_in = (frac != '0) ? KIND_NAN : KIND_INF;
        else if (bexp == '0 && frac == '0)
            kind_in = KIND_ZERO;
        else
            kind_in = KIND_FINITE;
    end

    assign done      = busy_reg && (kind_reg != KIND_FINITE || sig_reg[52]);
    assign norm_step = busy_reg && kind_reg == KIND_FINITE && !sig_reg[52];
    assign req.ready = !busy_reg || (done && desc_ready);
    assign accept    = req.valid && req.ready;
    assign lz        = lead_zeros(sig_reg[52:45]);

    // Sizing of the normalized significand and the written exponent
    assign sig56 = {sig_reg, 3'b000};
    assign mlen  = sig_len(sig56);
    assign xexp  = e_reg - {6'd0, mlen, 3'b000};
    assign xlen2 = |(xexp[11:7] ^ {5{xexp[11]}});

    assign desc_valid = done;
    always_comb
    begin
        desc.kind  = kind_reg;
        desc.neg   = neg_reg;
        desc.xlen2 = xlen2;
        desc.xexp  = xexp;
        desc.mlen  = mlen;
        desc.sig   = sig56;
        desc.total = 4'd2 + {3'd0, xlen2} + {1'b0, mlen};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (done && desc_ready)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_in;
            neg_reg  <= req.value_bits[63];
            if (bexp != '0)
            begin
                sig_reg <= {1'b1, frac};
                e_reg   <= {1'b0, bexp} - EXP_BIAS;
            end
            else
            begin
                sig_reg <= {1'b0, frac};
                e_reg   <= EXP_DENORM;
            end
        end
        else if (norm_step)
        begin
            // Shift a whole byte while the top byte is clear, else finish
            if (sig_reg[52:45] == 8'h00)
            begin
                sig_reg <= {sig_reg[44:0], 8'h00};
                e_reg   <= e_reg - 12'd8;
            end
            else
            begin
                sig_reg <= sig_reg << lz;
                e_reg   <= e_reg - {9'd0, lz};
            end
        end
    end

endmodule

// File: src/brce_queue.sv
// ----------------------------------------------------------------------------
// brce_queue
// Short descriptor queue between classification and octet emission.
// ----------------------------------------------------------------------------
module brce_queue #(
    parameter int DEPTH = brce_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  brce_pkg::desc_t push_data,
    output logic            head_valid,
    output brce_pkg::desc_t head,
    input  logic            pop
);
    import brce_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    desc_t             entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              push;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = count_reg != CntW'(DEPTH);
    assign push       = push_valid && push_ready;
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/brce_back.sv
// ----------------------------------------------------------------------------
// brce_back
// Walks the head descriptor one octet per beat into the output register.
// ----------------------------------------------------------------------------
module brce_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  brce_pkg::desc_t head,
    output logic            pop,
    brce_out_if.source      rsp
);
    import brce_pkg::*;

    logic [3:0]      k_reg;
    logic            valid_reg;
    logic [7:0]      octet_reg;
    logic            last_reg;
    logic            empty_reg;
    logic            invalid_reg;
    logic [3:0]      len_reg;

    logic            load;
    logic [7:0]      octet;
    logic            last;
    logic [3:0]      len;
    logic [3:0]      jw;
    logic [2:0]      j;
    logic [6:0][7:0] sig_bytes;
    logic [7:0]      x_hi;
    logic [7:0]      x_lo;

    assign load      = head_valid && (!valid_reg || rsp.ready);
    assign sig_bytes = head.sig;
    assign x_hi      = {{4{head.xexp[11]}}, head.xexp[11:8]};
    assign x_lo      = head.xexp[7:0];
    assign jw        = k_reg - 4'd2 - {3'd0, head.xlen2};
    assign j         = jw[2:0];

    always_comb
    begin
        octet = 8'h00;
        last  = 1'b1;
        len   = 4'd0;
        unique case (head.kind) inside
            KIND_FINITE:
            begin
                len  = head.total;
                last = k_reg == head.total - 4'd1;
                if (k_reg == 4'd0)
                    octet = FMT_BINARY | (head.neg ? FMT_NEG : 8'h00)
                            | {7'd0, head.xlen2};
                else if (k_reg == 4'd1)
                    octet = head.xlen2 ? x_hi : x_lo;
                else if (k_reg == 4'd2 && head.xlen2)
                    octet = x_lo;
                else
                    octet = sig_bytes[3'd6 - j];
            end
            KIND_INF:
            begin
                octet = head.neg ? OCT_NEG_INF : OCT_POS_INF;
                len   = 4'd1;
            end
            KIND_ZERO, KIND_NAN:
            begin
                octet = 8'h00;
            end
            default:
            begin
                octet = 8'h00;
            end
        endcase
    end

    assign pop = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                k_reg     <= last ? 4'd0 : k_reg + 4'd1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            octet_reg   <= octet;
            last_reg    <= last;
            empty_reg   <= head.kind == KIND_ZERO;
            invalid_reg <= head.kind == KIND_NAN;
            len_reg     <= len;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.octet          = octet_reg;
    assign rsp.last           = last_reg;
    assign rsp.empty_res      = empty_reg;
    assign rsp.invalid        = invalid_reg;
    assign rsp.content_length = len_reg;

endmodule

// File: src/ber_real_content_encoder.sv
// ----------------------------------------------------------------------------
// ber_real_content_encoder
// BER REAL content octets (base 2, F = 0) of a binary64 value.
// ----------------------------------------------------------------------------
// Input channel req carries one binary64 pattern per beat. Output channel rsp
// carries the content octets in transmission order, one per beat, with last
// on the final octet and content_length repeated on every octet. Zero and NaN
// give a single beat flagged empty_res or invalid; infinity gives one octet.
// A finite value gives 3 to 10 octets.
// A normal value passes the front registers, the descriptor queue and the
// output register; a denormal is first normalized in steps, each shifting
// out a whole byte of leading zeros or the final bit offset of the leading
// one. Throughput: while rsp is ready the octet sequencer sends one octet
// per cycle; a value holds the output for one beat per octet (1 to 10). The
// front classifies the next value meanwhile, parks it in the queue of
// QUEUE_DEPTH entries and takes a new value as soon as it hands one off.
// When rsp is stalled the output register holds its beat, the queue fills
// and then req.ready drops. Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module ber_real_content_encoder #(
    parameter int QUEUE_DEPTH = brce_pkg::QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    brce_in_if.sink    req,
    brce_out_if.source rsp
);
    import brce_pkg::*;

    logic  desc_valid;
    logic  desc_ready;
    desc_t desc;
    logic  head_valid;
    desc_t head;
    logic  pop;

    brce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    brce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (desc_valid),
        .push_ready (desc_ready),
        .push_data  (desc),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    brce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

    a_special_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.empty_res || rsp.invalid)
            |-> rsp.last && rsp.content_length == 4'd0)
        else $error("zero or NaN result is not a single empty beat");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.empty_res && rsp.invalid))
        else $error("empty and invalid flagged together");

    a_finite_length: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head.kind == KIND_FINITE
            |-> head.total >= 4'd3 && head.total <= 4'd10)
        else $error("finite value sized outside 3..10 octets");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp.valid && rsp.last)
        else $error("descriptor retired without a last beat");

endmodule
